@@ design/cppid_pkg.sv @@
`default_nettype none

package cppid_pkg;

  localparam int DefaultSignalWidth  = 24;
  localparam int DefaultFractionBits = 8;

  localparam int GainW    = 24;
  localparam int LimitW   = 31;
  localparam int DriveW   = 32;
  localparam int SumW     = 32;
  localparam int GainFrac = 16;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 31;

  localparam logic [GainW-1:0]  PropGainRst      = 24'd543949;
  localparam logic [GainW-1:0]  IntegGainRst     = 24'd16384;
  localparam logic [GainW-1:0]  DerivGainRst     = 24'd24904;
  localparam logic [LimitW-1:0] IntegralLimitRst = 31'd1024000;
  localparam logic [LimitW-1:0] DriveLimitRst    = 31'd1024000;

  typedef enum logic [1:0] {
    ModeNormal = 2'd0,
    ModeWhole  = 2'd1,
    ModeRate   = 2'd2
  } mode_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgPropGain      = 3'd0,
    CfgIntegGain     = 3'd1,
    CfgDerivGain     = 3'd2,
    CfgIntegralLimit = 3'd3,
    CfgDriveLimit    = 3'd4,
    CfgLoopMode      = 3'd5
  } cfg_idx_e;

endpackage

`default_nettype wire

@@ design/cppid_if.sv @@
`default_nettype none

interface cppid_in_if #(
  parameter int SIGNAL_WIDTH = cppid_pkg::DefaultSignalWidth
);
  logic                           valid;
  logic                           ready;
  logic signed [SIGNAL_WIDTH-1:0] setpoint;
  logic signed [SIGNAL_WIDTH-1:0] measured;
  logic signed [SIGNAL_WIDTH-1:0] measured_rate;

  modport source (output valid, output setpoint, output measured, output measured_rate,
                  input ready);
  modport sink   (input valid, input setpoint, input measured, input measured_rate,
                  output ready);
endinterface

interface cppid_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [cppid_pkg::DriveW-1:0] drive;

  modport source (output valid, output drive, input ready);
  modport sink   (input valid, input drive, output ready);
endinterface

`default_nettype wire

@@ design/clamped_positional_pid_core.sv @@
// An accepted word passes through the input-stage registers, the multiply-stage registers
// and the output register. One word per cycle unless the output stalls; the integral
// and last-error loop is at the input stage, then a multiply and a sum/shift/clamp stage.
// A stalled output word holds the pipeline back stage by stage; input ready drops only
// when all three stages are full. Reset (asynchronous, active low) empties the pipeline,
// clears the error integral and last error, and loads the register defaults.
`default_nettype none

module clamped_positional_pid_core #(
  parameter int SIGNAL_WIDTH  = cppid_pkg::DefaultSignalWidth,
  parameter int FRACTION_BITS = cppid_pkg::DefaultFractionBits
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [cppid_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [cppid_pkg::CfgDataW-1:0]  cfg_data_i,
  cppid_in_if.sink                             sample_i,
  cppid_out_if.source                          drive_o
);
  import cppid_pkg::*;

  localparam int ErrW     = SIGNAL_WIDTH + 1;
  localparam int DtW      = SIGNAL_WIDTH + 2;
  localparam int PreSumW  = ((ErrW > SumW) ? ErrW : SumW) + 1;
  localparam int PW       = GainW + 1 + ErrW;
  localparam int IW       = GainW + 1 + SumW;
  localparam int DW       = GainW + 1 + DtW;
  localparam int MaxPW    = (PW > IW) ? ((PW > DW) ? PW : DW) : ((IW > DW) ? IW : DW);
  localparam int AccW     = MaxPW + 2;

  localparam logic [ErrW-1:0]   WholeMaskE = {ErrW{1'b1}} << FRACTION_BITS;
  localparam logic [DriveW:0]   WholeMaskD = {(DriveW+1){1'b1}} << FRACTION_BITS;

  // Configuration registers
  logic [GainW-1:0]  pgain_q, igain_q, dgain_q;
  logic [LimitW-1:0] ilim_q, dlim_q;
  logic [1:0]        mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pgain_q <= PropGainRst;
      igain_q <= IntegGainRst;
      dgain_q <= DerivGainRst;
      ilim_q  <= IntegralLimitRst;
      dlim_q  <= DriveLimitRst;
      mode_q  <= ModeNormal;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CfgPropGain:      pgain_q <= cfg_data_i[GainW-1:0];
        CfgIntegGain:     igain_q <= cfg_data_i[GainW-1:0];
        CfgDerivGain:     dgain_q <= cfg_data_i[GainW-1:0];
        CfgIntegralLimit: ilim_q  <= cfg_data_i[LimitW-1:0];
        CfgDriveLimit:    dlim_q  <= cfg_data_i[LimitW-1:0];
        CfgLoopMode:      mode_q  <= cfg_data_i[1:0];
        default: ;
      endcase
    end
  end

  logic is_whole, is_rate;
  assign is_whole = (mode_q == ModeWhole);
  assign is_rate  = (mode_q == ModeRate);

  // Pipeline flow control
  logic v1_q, v2_q, v3_q;
  logic en1, en2, en3, accept;

  assign en3    = !v3_q || drive_o.ready;
  assign en2    = !v2_q || en3;
  assign en1    = !v1_q || en2;
  assign accept = sample_i.valid && en1;
  assign sample_i.ready = en1;

  // Input stage: error, clamped integral and derivative operand
  logic signed [SumW-1:0]    sum_q, sum_d;
  logic signed [ErrW-1:0]    prev_q;
  logic signed [ErrW-1:0]    sp_ext, ms_ext, err_raw, err_neg, err;
  logic signed [PreSumW-1:0] sum_a, sum_b, sum_pre, ilim_s, sum_clip;
  logic signed [DtW-1:0]     rate_ext, err_ext, prev_ext, dterm;

  always_comb begin
    sp_ext  = ErrW'(sample_i.setpoint);
    ms_ext  = ErrW'(sample_i.measured);
    err_raw = sp_ext - ms_ext;
    err_neg = -err_raw;
    if (is_whole) begin
      if (err_raw[ErrW-1]) begin
        err = -$signed(err_neg & WholeMaskE);
      end else begin
        err = $signed(err_raw & WholeMaskE);
      end
    end else begin
      err = err_raw;
    end

    sum_a   = PreSumW'(sum_q);
    sum_b   = PreSumW'(err);
    sum_pre = sum_a + sum_b;
    ilim_s  = $signed(PreSumW'(ilim_q));
    sum_clip = sum_pre;
    if (sum_clip >= ilim_s) begin
      sum_clip = ilim_s;
    end
    if (sum_clip <= -ilim_s) begin
      sum_clip = -ilim_s;
    end
    sum_d = sum_clip[SumW-1:0];

    rate_ext = DtW'(sample_i.measured_rate);
    err_ext  = DtW'(err);
    prev_ext = DtW'(prev_q);
    dterm    = is_rate ? rate_ext : (err_ext - prev_ext);
  end

  logic signed [ErrW-1:0] err1_q;
  logic signed [SumW-1:0] sum1_q;
  logic signed [DtW-1:0]  dt1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q  <= '0;
      prev_q <= '0;
    end else if (accept) begin
      sum_q  <= sum_d;
      prev_q <= err;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      err1_q <= err;
      sum1_q <= sum_d;
      dt1_q  <= dterm;
    end
  end

  // Multiply stage
  logic signed [PW-1:0] p2_q;
  logic signed [IW-1:0] i2_q;
  logic signed [DW-1:0] d2_q;

  always_ff @(posedge clk_i) begin
    if (en2) begin
      p2_q <= PW'($signed({1'b0, pgain_q})) * PW'(err1_q);
      i2_q <= IW'($signed({1'b0, igain_q})) * IW'(sum1_q);
      d2_q <= DW'($signed({1'b0, dgain_q})) * DW'(dt1_q);
    end
  end

  // Sum, floor shift, output clamp and whole-unit truncation
  logic signed [AccW-1:0]   acc_p, acc_i, acc_d, acc, shifted, dlim_s, clipped;
  logic signed [DriveW:0]   clip_n, clip_neg, drive_w;
  logic signed [DriveW-1:0] drive_d, drive_q;

  always_comb begin
    acc_p   = AccW'(p2_q);
    acc_i   = AccW'(i2_q);
    acc_d   = AccW'(d2_q);
    acc     = acc_p + acc_i + acc_d;
    shifted = acc >>> GainFrac;
    dlim_s  = $signed(AccW'(dlim_q));
    clipped = shifted;
    if (clipped >= dlim_s) begin
      clipped = dlim_s;
    end
    if (clipped <= -dlim_s) begin
      clipped = -dlim_s;
    end
    clip_n   = clipped[DriveW:0];
    clip_neg = -clip_n;
    if (is_whole) begin
      if (clip_n[DriveW]) begin
        drive_w = -$signed(clip_neg & WholeMaskD);
      end else begin
        drive_w = $signed(clip_n & WholeMaskD);
      end
    end else begin
      drive_w = clip_n;
    end
    drive_d = drive_w[DriveW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (en3) begin
      drive_q <= drive_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (en1) begin
        v1_q <= sample_i.valid;
      end
      if (en2) begin
        v2_q <= v1_q;
      end
      if (en3) begin
        v3_q <= v2_q;
      end
    end
  end

  assign drive_o.valid = v3_q;
  assign drive_o.drive = drive_q;

endmodule

`default_nettype wire

@@ design/cppid_checker.sv @@
`default_nettype none

module cppid_checker #(
  parameter int FRACTION_BITS = cppid_pkg::DefaultFractionBits
) (
  input wire logic                                clk_i,
  input wire logic                                rst_ni,
  input wire logic                                cfg_we_i,
  input wire logic [cppid_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input wire logic [cppid_pkg::CfgDataW-1:0]      cfg_data_i,
  input wire logic                                out_valid_i,
  input wire logic                                out_ready_i,
  input wire logic signed [cppid_pkg::DriveW-1:0] drive_i
);
  import cppid_pkg::*;

  localparam logic [DriveW-1:0] FracBits = ~({DriveW{1'b1}} << FRACTION_BITS);

  // Shadow copies of the registers that bound the output word.
  logic [LimitW-1:0] dlim_q;
  logic [1:0]        mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dlim_q <= DriveLimitRst;
      mode_q <= ModeNormal;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CfgDriveLimit) begin
        dlim_q <= cfg_data_i[LimitW-1:0];
      end
      if (cfg_idx_i == CfgLoopMode) begin
        mode_q <= cfg_data_i[1:0];
      end
    end
  end

  logic signed [DriveW:0] lim_s, drv_s;
  assign lim_s = $signed({2'b00, dlim_q});
  assign drv_s = (DriveW+1)'(drive_i);

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(drive_i))
    else $error("output word changed while stalled");

  a_drive_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (drv_s <= lim_s) && (drv_s >= -lim_s))
    else $error("drive outside the drive limit");

  a_whole_unit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (mode_q == ModeWhole) |-> ((drive_i & FracBits) == '0))
    else $error("whole-unit drive has fraction bits set");

  a_reset_empty: assert property (@(posedge clk_i)
    !rst_ni |-> !out_valid_i)
    else $error("output valid during reset");

endmodule

bind clamped_positional_pid_core cppid_checker #(
  .FRACTION_BITS(FRACTION_BITS)
) u_cppid_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .cfg_we_i    (cfg_we_i),
  .cfg_idx_i   (cfg_idx_i),
  .cfg_data_i  (cfg_data_i),
  .out_valid_i (drive_o.valid),
  .out_ready_i (drive_o.ready),
  .drive_i     (drive_o.drive)
);

`default_nettype wire
